[rtl/homogeneous_point_transform_3x3_assert.svh]
// ---------------------------------------------------------------------------
// homogeneous_point_transform_3x3_assert.svh
// Assertion macros for the point transform port checker. They expect clk and
// rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_3X3_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_3X3_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define HPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point transform port check failed");

// consequent checked in the same cycle as the antecedent
`define HPT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point transform port check failed");

`endif

[rtl/hpt_pkg.sv]
// ---------------------------------------------------------------------------
// hpt_pkg
// Shared types and codes of the 3x3 homogeneous point transform.
// ---------------------------------------------------------------------------
package hpt_pkg;

    localparam int unsigned IO_WIDTH    = 32;
    localparam int unsigned MAT_ENTRIES = 9;

    localparam logic [2:0] FUNC_LOAD_T     = 3'd0;
    localparam logic [2:0] FUNC_LOAD_M     = 3'd1;
    localparam logic [2:0] FUNC_COMPOSE    = 3'd2;
    localparam logic [2:0] FUNC_AFFINE     = 3'd3;
    localparam logic [2:0] FUNC_PROJECTIVE = 3'd4;

    typedef struct packed {
        logic [2:0]                 func;
        logic [3:0]                 entry_index;
        logic signed [IO_WIDTH-1:0] entry_value;
        logic signed [IO_WIDTH-1:0] point_x;
        logic signed [IO_WIDTH-1:0] point_y;
        logic signed [IO_WIDTH-1:0] point_z;
        logic                       last_point;
    } req_t;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] out_x;
        logic signed [IO_WIDTH-1:0] out_y;
        logic                       zero_divisor;
        logic                       out_last;
    } rsp_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;    // preload the rounding half
        logic issue;  // multiply this cycle
        logic half;   // high half of the b magnitude
        logic konst;  // constant term: a times 1.0
    } mac_op_t;

endpackage

[rtl/hpt_stream_if.sv]
// ---------------------------------------------------------------------------
// hpt_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface hpt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/hpt_mac.sv]
// ---------------------------------------------------------------------------
// hpt_mac
// Shared multiply-accumulate unit: one W x W/2 partial product a cycle,
// registered, then added into an exact accumulator. Result is the rounded,
// saturated word of the accumulator.
// ---------------------------------------------------------------------------
module hpt_mac #(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hpt_pkg::mac_op_t             op,
    input  logic signed [WORD_WIDTH-1:0] a,
    input  logic signed [WORD_WIDTH-1:0] b,
    output logic signed [WORD_WIDTH-1:0] result
);
    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned HB = (W + 1) / 2;
    localparam int unsigned PW = W + HB;
    localparam int unsigned MW = (W > F) ? W : F;
    localparam int unsigned AW = W + MW + 2;

    localparam logic signed [AW-1:0] HALF = AW'(1) << (F - 1);
    localparam logic signed [AW-1:0] WMAX = (AW'(1) << (W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] WMIN = ~WMAX;

    logic [W-1:0]  a_mag;
    logic [W-1:0]  b_mag;
    logic [HB-1:0] b_half;
    logic [PW-1:0] mul;

    logic [PW-1:0]          prod_reg;
    logic                   neg_reg;
    logic                   half_reg;
    logic                   konst_reg;
    logic                   vld_reg;
    logic signed [AW-1:0]   acc_reg;

    logic [AW-1:0]          shifted;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   rs;

    assign a_mag  = a[W-1] ? (~$unsigned(a) + W'(1)) : $unsigned(a);
    assign b_mag  = b[W-1] ? (~$unsigned(b) + W'(1)) : $unsigned(b);
    assign b_half = op.half ? HB'(b_mag >> HB) : b_mag[HB-1:0];
    assign mul    = PW'(a_mag) * PW'(b_half);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= op.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.issue)
        begin
            prod_reg  <= op.konst ? PW'(a_mag) : mul;
            neg_reg   <= op.konst ? a[W-1] : (a[W-1] ^ b[W-1]);
            half_reg  <= op.half;
            konst_reg <= op.konst;
        end
        if (op.clr)
        begin
            acc_reg <= HALF;
        end
        else if (vld_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    // align the partial product: high half sits HB bits up, constant term F bits up
    always_comb
    begin
        if (konst_reg)
        begin
            shifted = AW'(prod_reg) << F;
        end
        else if (half_reg)
        begin
            shifted = AW'(prod_reg) << HB;
        end
        else
        begin
            shifted = AW'(prod_reg);
        end
    end

    assign term = neg_reg ? $signed(~shifted + AW'(1)) : $signed(shifted);

    assign rs = acc_reg >>> F;

    always_comb
    begin
        if (rs > WMAX)
        begin
            result = WMAX[W-1:0];
        end
        else if (rs < WMIN)
        begin
            result = WMIN[W-1:0];
        end
        else
        begin
            result = rs[W-1:0];
        end
    end

endmodule

[rtl/hpt_div.sv]
// ---------------------------------------------------------------------------
// hpt_div
// Radix-2 restoring divider: num * 2^F / den on magnitudes, one quotient bit
// a cycle, truncated toward zero and saturated to a signed word.
// ---------------------------------------------------------------------------
module hpt_div #(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [WORD_WIDTH-1:0] num,
    input  logic signed [WORD_WIDTH-1:0] den,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] quot
);
    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned NW = W + F;
    localparam int unsigned CW = $clog2(NW + 1);

    localparam logic [NW-1:0] QMAX_POS = (NW'(1) << (W - 1)) - NW'(1);
    localparam logic [NW-1:0] QMAX_NEG = NW'(1) << (W - 1);
    localparam logic [W-1:0]  WMAX     = (W'(1) << (W - 1)) - W'(1);
    localparam logic [W-1:0]  WMIN     = W'(1) << (W - 1);

    logic [W-1:0]  num_mag;
    logic [W-1:0]  den_mag;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  ud_reg;
    logic [NW-1:0] dsr_reg;
    logic [W-1:0]  rem_reg;
    logic [NW-1:0] q_reg;
    logic          neg_reg;
    logic [W-1:0]  quot_reg;

    logic [W:0]    rem_sh;
    logic          ge;
    logic [W:0]    rem_sub;
    logic [NW-1:0] q_fin;

    assign num_mag = num[W-1] ? (~$unsigned(num) + W'(1)) : $unsigned(num);
    assign den_mag = den[W-1] ? (~$unsigned(den) + W'(1)) : $unsigned(den);

    assign rem_sh  = {rem_reg, dsr_reg[NW-1]};
    assign ge      = (rem_sh >= {1'b0, ud_reg});
    assign rem_sub = rem_sh - {1'b0, ud_reg};
    assign q_fin   = {q_reg[NW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ud_reg  <= den_mag;
            dsr_reg <= {num_mag, F'(0)};
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= num[W-1] ^ den[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            dsr_reg <= dsr_reg << 1;
            q_reg   <= q_fin;
            // final bit: saturate and apply the sign
            if (cnt_reg == CW'(1))
            begin
                if (neg_reg)
                begin
                    quot_reg <= (q_fin > QMAX_NEG) ? WMIN : (~q_fin[W-1:0] + W'(1));
                end
                else
                begin
                    quot_reg <= (q_fin > QMAX_POS) ? WMAX : q_fin[W-1:0];
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = $signed(quot_reg);

endmodule

[rtl/homogeneous_point_transform_3x3.sv]
// ---------------------------------------------------------------------------
// homogeneous_point_transform_3x3
// 3x3 homogeneous point transform with matrix load, compose, affine and
// projective point words, on one shared multiplier and one divider.
//
// Channel  Direction  Payload         Handshake
// req      in         hpt_pkg::req_t  valid/ready
// rsp      out        hpt_pkg::rsp_t  valid/ready
//
// Load and unknown words stay in idle. A three-term dot product on the
// shared multiplier takes two half products per term (one for the affine
// constant term) and two drain steps. Affine: x, y dots; compose: nine dots,
// row by row; projective: w, x, y dots, then divides x, y by w unless w is 0.
// Reset clears both matrices at once. A stalled rsp word holds in the output
// register while the next word is accepted; a later point waits to load it.
// ---------------------------------------------------------------------------
module homogeneous_point_transform_3x3 #(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    hpt_stream_if.sink   req,
    hpt_stream_if.source rsp
);
    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned IW = hpt_pkg::IO_WIDTH;
    localparam int unsigned XW = (W > IW) ? W : IW;
    localparam int unsigned SW = XW + 1;
    localparam int unsigned NE = hpt_pkg::MAT_ENTRIES;

    localparam logic signed [SW-1:0] SMAX = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DOT  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] PH_W  = 2'd0;
    localparam logic [1:0] PH_NX = 2'd1;
    localparam logic [1:0] PH_NY = 2'd2;

    localparam logic [2:0] STEP_DRAIN = 3'd6;
    localparam logic [2:0] STEP_LAST  = 3'd7;
    localparam logic [1:0] LAST_IDX   = 2'd2;

    function automatic logic signed [W-1:0] sat_in(input logic signed [IW-1:0] v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > SMAX)
        begin
            return SMAX[W-1:0];
        end
        else if (e < SMIN)
        begin
            return SMIN[W-1:0];
        end
        return e[W-1:0];
    endfunction

    function automatic logic signed [IW-1:0] to_io(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        e = XW'(v);
        return e[IW-1:0];
    endfunction

    function automatic logic [3:0] rc_idx(input logic [1:0] r, input logic [1:0] c);
        return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
    endfunction

    logic [1:0]          state_reg;
    logic [2:0]          step_reg;
    logic [1:0]          row_reg;
    logic [1:0]          col_reg;
    logic [1:0]          phase_reg;
    logic [2:0]          op_reg;
    logic                dsel_reg;
    logic                div_start_reg;
    logic                rsp_valid_reg;
    hpt_pkg::rsp_t       rsp_data_reg;

    logic signed [W-1:0] tm_reg [NE];
    logic signed [W-1:0] mm_reg [NE];
    logic signed [W-1:0] rowbuf_reg [2];

    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic signed [W-1:0] z_reg;
    logic                last_reg;
    logic signed [W-1:0] rx_reg;
    logic signed [W-1:0] ry_reg;
    logic signed [W-1:0] w_reg;
    logic                zd_reg;

    logic                accept;
    logic                capture;
    logic                rsp_load;
    logic                is_comp;
    logic                is_proj;
    logic [1:0]          k_sel;
    hpt_pkg::mac_op_t    mac_op;
    logic signed [W-1:0] mac_a;
    logic signed [W-1:0] mac_b;
    logic signed [W-1:0] dot_res;
    logic                div_done;
    logic signed [W-1:0] div_quot;
    logic signed [W-1:0] div_num;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign capture   = (state_reg == ST_DOT) && (step_reg == STEP_LAST);
    assign rsp_load  = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp.ready);
    assign is_comp   = (op_reg == hpt_pkg::FUNC_COMPOSE);
    assign is_proj   = (op_reg == hpt_pkg::FUNC_PROJECTIVE);

    // term index; hold the last term through the drain steps
    assign k_sel = (step_reg[2:1] > LAST_IDX) ? LAST_IDX : step_reg[2:1];

    always_comb
    begin
        mac_op.clr   = (state_reg == ST_DOT) && (step_reg == '0);
        mac_op.half  = step_reg[0];
        mac_op.konst = !is_comp && !is_proj && (k_sel == LAST_IDX);
        mac_op.issue = (state_reg == ST_DOT) && (step_reg < STEP_DRAIN)
                       && !(mac_op.konst && step_reg[0]);
        if (is_comp)
        begin
            mac_a = tm_reg[rc_idx(row_reg, k_sel)];
            mac_b = mm_reg[rc_idx(k_sel, col_reg)];
        end
        else
        begin
            mac_b = tm_reg[rc_idx(k_sel, col_reg)];
            case (k_sel)
                2'd0:    mac_a = x_reg;
                2'd1:    mac_a = y_reg;
                default: mac_a = mac_op.konst ? mac_b : z_reg;
            endcase
        end
    end

    hpt_mac #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mac_op),
        .a      (mac_a),
        .b      (mac_b),
        .result (dot_res)
    );

    assign div_num = dsel_reg ? ry_reg : rx_reg;

    hpt_div #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (w_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= PH_NX;
            op_reg        <= hpt_pkg::FUNC_LOAD_T;
            dsel_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NE; i++)
            begin
                tm_reg[i] <= '0;
                mm_reg[i] <= '0;
            end
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= req.data.func;
                        step_reg <= '0;
                        row_reg  <= '0;
                        case (req.data.func)
                            hpt_pkg::FUNC_LOAD_T:
                            begin
                                if (req.data.entry_index < 4'(NE))
                                begin
                                    tm_reg[req.data.entry_index] <= sat_in(req.data.entry_value);
                                end
                            end
                            hpt_pkg::FUNC_LOAD_M:
                            begin
                                if (req.data.entry_index < 4'(NE))
                                begin
                                    mm_reg[req.data.entry_index] <= sat_in(req.data.entry_value);
                                end
                            end
                            hpt_pkg::FUNC_COMPOSE:
                            begin
                                col_reg   <= '0;
                                state_reg <= ST_DOT;
                            end
                            hpt_pkg::FUNC_AFFINE:
                            begin
                                col_reg   <= 2'd0;
                                phase_reg <= PH_NX;
                                state_reg <= ST_DOT;
                            end
                            hpt_pkg::FUNC_PROJECTIVE:
                            begin
                                col_reg   <= LAST_IDX;
                                phase_reg <= PH_W;
                                state_reg <= ST_DOT;
                            end
                            default:
                            begin
                                // unknown word: drop
                            end
                        endcase
                    end
                end
                ST_DOT:
                begin
                    if (capture)
                    begin
                        step_reg <= '0;
                        if (is_comp)
                        begin
                            if (col_reg == LAST_IDX)
                            begin
                                // row done: commit it over the old row
                                tm_reg[rc_idx(row_reg, 2'd0)] <= rowbuf_reg[0];
                                tm_reg[rc_idx(row_reg, 2'd1)] <= rowbuf_reg[1];
                                tm_reg[rc_idx(row_reg, LAST_IDX)] <= dot_res;
                                col_reg <= '0;
                                if (row_reg == LAST_IDX)
                                begin
                                    state_reg <= ST_IDLE;
                                end
                                else
                                begin
                                    row_reg <= row_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                col_reg <= col_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_W:
                                begin
                                    if (dot_res == '0)
                                    begin
                                        state_reg <= ST_OUT;
                                    end
                                    else
                                    begin
                                        phase_reg <= PH_NX;
                                        col_reg   <= 2'd0;
                                    end
                                end
                                PH_NX:
                                begin
                                    phase_reg <= PH_NY;
                                    col_reg   <= 2'd1;
                                end
                                default:
                                begin
                                    if (is_proj)
                                    begin
                                        state_reg     <= ST_DIV;
                                        dsel_reg      <= 1'b0;
                                        div_start_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_OUT;
                                    end
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (!dsel_reg)
                        begin
                            dsel_reg      <= 1'b1;
                            div_start_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sat_in(req.data.point_x);
            y_reg    <= sat_in(req.data.point_y);
            z_reg    <= sat_in(req.data.point_z);
            last_reg <= req.data.last_point;
            zd_reg   <= 1'b0;
        end
        if (capture && is_comp && (col_reg != LAST_IDX))
        begin
            rowbuf_reg[col_reg[0]] <= dot_res;
        end
        if (capture && !is_comp)
        begin
            case (phase_reg)
                PH_W:
                begin
                    w_reg <= dot_res;
                    if (dot_res == '0)
                    begin
                        rx_reg <= '0;
                        ry_reg <= '0;
                        zd_reg <= 1'b1;
                    end
                end
                PH_NX:   rx_reg <= dot_res;
                default: ry_reg <= dot_res;
            endcase
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            if (!dsel_reg)
            begin
                rx_reg <= div_quot;
            end
            else
            begin
                ry_reg <= div_quot;
            end
        end
        if (rsp_load)
        begin
            rsp_data_reg.out_x        <= to_io(rx_reg);
            rsp_data_reg.out_y        <= to_io(ry_reg);
            rsp_data_reg.zero_divisor <= zd_reg;
            rsp_data_reg.out_last     <= last_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

[rtl/hpt_checker.sv]
// ---------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the point transform, bound to the top level.
// ---------------------------------------------------------------------------
`include "homogeneous_point_transform_3x3_assert.svh"

module hpt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic [2:0]    req_func,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input hpt_pkg::rsp_t rsp_data
);
    logic req_acc;
    logic is_work;

    assign req_acc = req_valid && req_ready;
    assign is_work = (req_func == hpt_pkg::FUNC_COMPOSE) ||
                     (req_func == hpt_pkg::FUNC_AFFINE) ||
                     (req_func == hpt_pkg::FUNC_PROJECTIVE);

    // a stalled result word stays up and unchanged
    `HPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `HPT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))

    // compose and point words occupy the shared unit; loads and unknown words do not
    `HPT_ASSERT_NEXT(a_busy_after_work, req_acc && is_work, !req_ready)
    `HPT_ASSERT_NEXT(a_ready_after_load, req_acc && !is_work, req_ready)

    // zero divisor always comes with zero coordinates
    `HPT_ASSERT_NOW(a_zero_div_coords, rsp_valid && rsp_data.zero_divisor,
                    (rsp_data.out_x == '0) && (rsp_data.out_y == '0))

endmodule

bind homogeneous_point_transform_3x3 hpt_checker u_hpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.data.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
